>>> src/sha1_pkg.sv
// Shared types, constants and helper functions for the SHA-1 hash engine.
// Used by sha1_sched, sha1_round and sha1_hash_engine_top; depends on nothing.
package sha1_pkg;

  localparam int unsigned NUM_CHAIN  = 5;
  localparam int unsigned BUF_DEPTH  = 16;
  localparam int unsigned NUM_ROUNDS = 80;

  typedef logic [31:0] word_t;
  typedef logic [3:0]  pos_t;
  typedef logic [6:0]  rnd_t;
  typedef logic [2:0]  chain_idx_t;

  localparam rnd_t LAST_ROUND = rnd_t'(NUM_ROUNDS - 1);
  localparam pos_t POS_LAST   = pos_t'(BUF_DEPTH - 1);
  localparam pos_t POS_LEN_HI = pos_t'(BUF_DEPTH - 2);
  localparam chain_idx_t LAST_CHAIN = chain_idx_t'(NUM_CHAIN - 1);

  localparam word_t PAD_WORD = 32'h8000_0000;
  localparam logic [2:0] FULL_BYTES = 3'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  // Schedule buffer control: push loads a message or padding word, step expands one round
  typedef struct packed {
    logic  push;
    logic  step;
    word_t data;
  } sched_ctl_t;

  // Round unit control: load takes the chaining words, step runs one round
  typedef struct packed {
    logic load;
    logic step;
  } round_ctl_t;

  // Initial chaining value
  function automatic word_t sha1_iv(input chain_idx_t idx);
    word_t v;
    unique case (idx)
      3'd0:    v = 32'h6745_2301;
      3'd1:    v = 32'hEFCD_AB89;
      3'd2:    v = 32'h98BA_DCFE;
      3'd3:    v = 32'h1032_5476;
      default: v = 32'hC3D2_E1F0;
    endcase
    return v;
  endfunction

  // Round constant for round index
  function automatic word_t sha1_k(input rnd_t rnd);
    word_t k;
    priority if (rnd < 7'd20) begin
      k = 32'h5A82_7999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ED9_EBA1;
    end else if (rnd < 7'd60) begin
      k = 32'h8F1B_BCDC;
    end else begin
      k = 32'hCA62_C1D6;
    end
    return k;
  endfunction

  // Boolean round function for round index
  function automatic word_t sha1_f(input rnd_t rnd, input word_t b, input word_t c,
                                   input word_t d);
    word_t f;
    priority if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // Keep the valid leading bytes of a short final word and place the 0x80 marker
  function automatic word_t sha1_pad_word(input word_t w, input logic [2:0] cnt);
    word_t r;
    unique case (cnt)
      3'd0:    r = PAD_WORD;
      3'd1:    r = {w[31:24], 24'h80_0000};
      3'd2:    r = {w[31:16], 16'h8000};
      3'd3:    r = {w[31:8], 8'h80};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

>>> src/sha1_sched.sv
// Sixteen-word block buffer and message schedule as a shift line.
// Depends on sha1_pkg.
module sha1_sched (
  input  logic                clk,
  input  sha1_pkg::sched_ctl_t ctl,
  output sha1_pkg::word_t     w_out
);

  sha1_pkg::word_t buf_r [sha1_pkg::BUF_DEPTH];
  sha1_pkg::word_t exp_w;

  // Expand the word sixteen rounds ahead from the current window
  assign exp_w = buf_r[13] ^ buf_r[8] ^ buf_r[2] ^ buf_r[0];
  assign w_out = buf_r[0];

  // Advance the window on a load or a round
  always_ff @(posedge clk) begin
    if (ctl.push || ctl.step) begin
      for (int i = 0; i < sha1_pkg::BUF_DEPTH - 1; i++) begin
        buf_r[i] <= buf_r[i + 1];
      end
      buf_r[sha1_pkg::BUF_DEPTH - 1] <= ctl.push ? ctl.data : {exp_w[30:0], exp_w[31]};
    end
  end

endmodule

>>> src/sha1_round.sv
// Working variables a..e and the shared single-round compression unit.
// Depends on sha1_pkg.
module sha1_round (
  input  logic                 clk,
  input  sha1_pkg::round_ctl_t ctl,
  input  sha1_pkg::rnd_t       rnd,
  input  sha1_pkg::word_t      w_in,
  input  sha1_pkg::word_t      chain_in [sha1_pkg::NUM_CHAIN],
  output sha1_pkg::word_t      vars_out [sha1_pkg::NUM_CHAIN]
);

  sha1_pkg::word_t a_r, b_r, c_r, d_r, e_r;
  sha1_pkg::word_t tmp;

  // One round: rotated a plus f, e, k and schedule word
  assign tmp = {a_r[26:0], a_r[31:27]} + sha1_pkg::sha1_f(rnd, b_r, c_r, d_r) + e_r
               + sha1_pkg::sha1_k(rnd) + w_in;

  // Load chaining words or run one round
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= chain_in[0];
      b_r <= chain_in[1];
      c_r <= chain_in[2];
      d_r <= chain_in[3];
      e_r <= chain_in[4];
    end else if (ctl.step) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  assign vars_out[0] = a_r;
  assign vars_out[1] = b_r;
  assign vars_out[2] = c_r;
  assign vars_out[3] = d_r;
  assign vars_out[4] = e_r;

endmodule

>>> src/sha1_hash_engine_top.sv
// SHA-1 hash engine: takes 32-bit big-endian message words and returns five digest words.
// Depends on sha1_pkg, sha1_sched and sha1_round.
//
// Every sixteenth message word fills a block, and the block is then compressed by a single
// round unit at one round per cycle, after which the result is folded into the chaining
// words. On the word marked last the engine pushes the padding and the 64-bit length one
// word per cycle, compresses one or two final blocks the same way, and then offers the
// five digest words h0..h4, one per cycle when the sink does not stall, the fifth flagged
// by out_digest_last. The input stalls throughout compression, padding and digest output,
// and the engine is ready for a new message once the fifth word is taken.
module sha1_hash_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_msg_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);

  sha1_pkg::state_t     state_r, state_nxt;
  sha1_pkg::pos_t       pos_r;
  logic [63:0]          len_r;
  sha1_pkg::rnd_t       round_r;
  logic                 need80_r;
  logic                 lenlo_r;
  logic                 done_r;
  logic                 fin_r;
  sha1_pkg::chain_idx_t out_idx_r;
  sha1_pkg::word_t      chain_r [sha1_pkg::NUM_CHAIN];
  sha1_pkg::word_t      vars [sha1_pkg::NUM_CHAIN];
  sha1_pkg::word_t      sched_w;

  sha1_pkg::sched_ctl_t sch_ctl;
  sha1_pkg::round_ctl_t rnd_ctl;

  logic       in_acc;
  logic       out_acc;
  logic [2:0] cnt_sat;
  logic [6:0] len_inc;
  logic       wrap;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign cnt_sat = in_byte_count[2] ? sha1_pkg::FULL_BYTES : in_byte_count;
  assign len_inc = in_last_word ? {1'b0, cnt_sat, 3'b000} : 7'd32;
  assign wrap    = sch_ctl.push && (pos_r == sha1_pkg::POS_LAST);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha1_pkg::S_IDLE: begin
        if (in_acc) begin
          priority if (pos_r == sha1_pkg::POS_LAST) begin
            state_nxt = sha1_pkg::S_ROUND;
          end else if (in_last_word) begin
            state_nxt = sha1_pkg::S_PAD;
          end else begin
            state_nxt = sha1_pkg::S_IDLE;
          end
        end
      end
      sha1_pkg::S_PAD: begin
        if (pos_r == sha1_pkg::POS_LAST) begin
          state_nxt = sha1_pkg::S_ROUND;
        end
      end
      sha1_pkg::S_ROUND: begin
        if (round_r == sha1_pkg::LAST_ROUND) begin
          state_nxt = sha1_pkg::S_ADD;
        end
      end
      sha1_pkg::S_ADD: begin
        priority if (done_r) begin
          state_nxt = sha1_pkg::S_OUT;
        end else if (fin_r) begin
          state_nxt = sha1_pkg::S_PAD;
        end else begin
          state_nxt = sha1_pkg::S_IDLE;
        end
      end
      sha1_pkg::S_OUT: begin
        if (out_acc && (out_idx_r == sha1_pkg::LAST_CHAIN)) begin
          state_nxt = sha1_pkg::S_IDLE;
        end
      end
      default: state_nxt = sha1_pkg::S_IDLE;
    endcase
  end

  // Handshake and datapath control
  always_comb begin
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    sch_ctl.push = 1'b0;
    sch_ctl.step = 1'b0;
    sch_ctl.data = in_msg_word;
    rnd_ctl.step = 1'b0;
    unique case (state_r)
      sha1_pkg::S_IDLE: begin
        in_stall     = 1'b0;
        sch_ctl.push = in_valid;
        if (in_last_word && !cnt_sat[2]) begin
          sch_ctl.data = sha1_pkg::sha1_pad_word(in_msg_word, cnt_sat);
        end
      end
      sha1_pkg::S_PAD: begin
        sch_ctl.push = 1'b1;
        priority if (need80_r) begin
          sch_ctl.data = sha1_pkg::PAD_WORD;
        end else if (lenlo_r) begin
          sch_ctl.data = len_r[31:0];
        end else if (pos_r == sha1_pkg::POS_LEN_HI) begin
          sch_ctl.data = len_r[63:32];
        end else begin
          sch_ctl.data = '0;
        end
      end
      sha1_pkg::S_ROUND: begin
        sch_ctl.step = 1'b1;
        rnd_ctl.step = 1'b1;
      end
      sha1_pkg::S_ADD: begin
      end
      sha1_pkg::S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
    rnd_ctl.load = wrap;
  end

  assign out_digest_word = chain_r[out_idx_r];
  assign out_digest_last = (out_idx_r == sha1_pkg::LAST_CHAIN);

  // Hold sequencer, counters and chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sha1_pkg::S_IDLE;
      pos_r     <= '0;
      len_r     <= '0;
      round_r   <= '0;
      need80_r  <= 1'b0;
      lenlo_r   <= 1'b0;
      done_r    <= 1'b0;
      fin_r     <= 1'b0;
      out_idx_r <= '0;
      for (int i = 0; i < sha1_pkg::NUM_CHAIN; i++) begin
        chain_r[i] <= sha1_pkg::sha1_iv(sha1_pkg::chain_idx_t'(i));
      end
    end else begin
      state_r <= state_nxt;
      if (sch_ctl.push) begin
        pos_r <= pos_r + 4'd1;
      end
      if (in_acc) begin
        len_r <= len_r + {57'd0, len_inc};
        if (in_last_word) begin
          fin_r    <= 1'b1;
          need80_r <= cnt_sat[2];
        end
      end
      // Track the padding tail
      if (state_r == sha1_pkg::S_PAD) begin
        priority if (need80_r) begin
          need80_r <= 1'b0;
        end else if (lenlo_r) begin
          lenlo_r <= 1'b0;
          done_r  <= 1'b1;
        end else if (pos_r == sha1_pkg::POS_LEN_HI) begin
          lenlo_r <= 1'b1;
        end else begin
          // zero fill: nothing to track
        end
      end
      // Advance the round counter
      if (rnd_ctl.step) begin
        round_r <= (round_r == sha1_pkg::LAST_ROUND) ? '0 : round_r + 7'd1;
      end
      // Fold the working variables into the chain
      if (state_r == sha1_pkg::S_ADD) begin
        for (int i = 0; i < sha1_pkg::NUM_CHAIN; i++) begin
          chain_r[i] <= chain_r[i] + vars[i];
        end
      end
      // Step through the digest words, then drop back to a fresh message
      if (out_acc) begin
        if (out_idx_r == sha1_pkg::LAST_CHAIN) begin
          out_idx_r <= '0;
          len_r     <= '0;
          fin_r     <= 1'b0;
          done_r    <= 1'b0;
          for (int i = 0; i < sha1_pkg::NUM_CHAIN; i++) begin
            chain_r[i] <= sha1_pkg::sha1_iv(sha1_pkg::chain_idx_t'(i));
          end
        end else begin
          out_idx_r <= out_idx_r + 3'd1;
        end
      end
    end
  end

  sha1_sched u_sched (
    .clk   (clk),
    .ctl   (sch_ctl),
    .w_out (sched_w)
  );

  sha1_round u_round (
    .clk      (clk),
    .ctl      (rnd_ctl),
    .rnd      (round_r),
    .w_in     (sched_w),
    .chain_in (chain_r),
    .vars_out (vars)
  );

  // Digest words only appear with the block buffer empty
  a_out_empty_buf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pos_r == '0))
    else $error("digest offered with partly filled block");

  // Loading and expanding the schedule never coincide
  a_push_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sch_ctl.push && sch_ctl.step))
    else $error("schedule push during a round");

  // A round pass starts exactly when the block fills
  a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
    wrap |=> (state_r == sha1_pkg::S_ROUND) && (round_r == '0))
    else $error("block full without a round pass");

  // A mid-block message word leaves the input ready again
  a_mid_word_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_last_word && (pos_r != sha1_pkg::POS_LAST) |=> !in_stall)
    else $error("input stalled after a mid-block word");

  // Taking the last digest word frees the input for the next message
  a_last_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_digest_last |=> !in_stall && (len_r == '0))
    else $error("engine not cleared after the digest");

endmodule

>>> bench/tb.sv
// Self-checking bench for sha1_hash_engine_top: feeds whole messages, one word per
// handshake, with random gaps and sink stalls, and checks every digest word in order.
// Depends on sha1_pkg and the engine RTL; predicts digests with its own SHA-1 model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 250;
  localparam int RANDOM_WORDS   = 358;

  localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
  localparam logic [159:0] ABC_DIGEST   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;
  localparam logic [159:0] NO_DIGEST    = '0;

  // One directed input word; the digest is only used when fixed is set
  typedef struct packed {
    sha1_pkg::word_t data;
    logic [2:0]      count;
    logic            last;
    logic            fixed;
    logic [159:0]    digest;
  } stim_row_t;

  typedef struct packed {
    sha1_pkg::word_t word;
    logic            last;
  } digest_beat_t;

  localparam int DIR_ROWS = 12;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty message, clean and with junk in the ignored word
    '{32'h0000_0000, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
    '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
    // "abc" with a junk byte below the valid ones
    '{32'h6162_63FF, 3'd3, 1'b1, 1'b1, ABC_DIGEST},
    // short final words
    '{32'hFFFF_FFFF, 3'd1, 1'b1, 1'b0, NO_DIGEST},
    '{32'h0000_0000, 3'd2, 1'b1, 1'b0, NO_DIGEST},
    // full final word, then counts above four that clamp
    '{32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0, NO_DIGEST},
    '{32'h0000_0000, 3'd5, 1'b1, 1'b0, NO_DIGEST},
    '{32'h1234_5678, 3'd7, 1'b1, 1'b0, NO_DIGEST},
    // mid-message words ignore their count, then a final word whose count clamps
    '{32'h0000_0000, 3'd0, 1'b0, 1'b0, NO_DIGEST},
    '{32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0, NO_DIGEST},
    '{32'h5555_AAAA, 3'd3, 1'b0, 1'b0, NO_DIGEST},
    '{32'hAAAA_5555, 3'd6, 1'b1, 1'b0, NO_DIGEST}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_msg_word;
  logic [2:0]  in_byte_count;
  logic        in_last_word;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic        out_digest_last;

  // Digest model state
  sha1_pkg::word_t chain_h [5];
  sha1_pkg::word_t blk_w [16];
  sha1_pkg::pos_t  fill_pos;
  logic [63:0]     msg_bits;
  digest_beat_t    digest_q [$];

  int fails;
  int idle_cycles;
  int words_in;
  int messages;
  int digests_seen;

  sha1_hash_engine_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_msg_word    (in_msg_word),
    .in_byte_count  (in_byte_count),
    .in_last_word   (in_last_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digest_word(out_digest_word),
    .out_digest_last(out_digest_last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sha1_pkg::word_t rol(sha1_pkg::word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Restart the chain from the initial vector with an empty block
  function automatic void start_message();
    chain_h[0] = 32'h6745_2301;
    chain_h[1] = 32'hEFCD_AB89;
    chain_h[2] = 32'h98BA_DCFE;
    chain_h[3] = 32'h1032_5476;
    chain_h[4] = 32'hC3D2_E1F0;
    fill_pos   = '0;
    msg_bits   = '0;
  endfunction

  // Run the 80 rounds over the buffered block and fold into the chain
  function automatic void sha1_compress_block();
    sha1_pkg::word_t sched [16];
    sha1_pkg::word_t a, b, c, d, e, f, k, tmp, wt;
    sched = blk_w;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = sched[r];
      end else begin
        wt = rol(sched[(r - 3) & 15] ^ sched[(r - 8) & 15] ^ sched[(r - 14) & 15] ^
                 sched[r & 15], 1);
        sched[r & 15] = wt;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A82_7999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9_EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1B_BCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62_C1D6;
      end
      tmp = rol(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = tmp;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Fill the next block slot; a full block is compressed at once
  function automatic void load_block_word(sha1_pkg::word_t wd);
    blk_w[fill_pos] = wd;
    fill_pos = fill_pos + 4'd1;
    if (fill_pos == '0) begin
      sha1_compress_block();
    end
  endfunction

  // Absorb one accepted word; a final word pads, finishes and queues the digest
  function automatic void absorb_msg_word(sha1_pkg::word_t wd, logic [2:0] cnt, logic lst,
                                          logic fixed, logic [159:0] known);
    logic [2:0]      n;
    sha1_pkg::word_t keep;
    digest_beat_t    beat;
    if (!lst) begin
      msg_bits += 64'd32;
      load_block_word(wd);
      return;
    end
    n = (cnt > sha1_pkg::FULL_BYTES) ? sha1_pkg::FULL_BYTES : cnt;
    msg_bits += 64'(n) * 64'd8;
    if (n == sha1_pkg::FULL_BYTES) begin
      load_block_word(wd);
      load_block_word(sha1_pkg::PAD_WORD);
    end else begin
      keep = (n == 3'd0) ? '0 : ~(32'hFFFF_FFFF >> (8 * n));
      load_block_word((wd & keep) | (sha1_pkg::PAD_WORD >> (8 * n)));
    end
    while (fill_pos != sha1_pkg::POS_LEN_HI) begin
      load_block_word('0);
    end
    load_block_word(msg_bits[63:32]);
    load_block_word(msg_bits[31:0]);
    for (int i = 0; i < 5; i++) begin
      beat.word = fixed ? known[159 - 32 * i -: 32] : chain_h[i];
      beat.last = (i == 4);
      digest_q.insert(digest_q.size(), beat);
    end
    start_message();
  endfunction

  // Offer one word after a random gap and hold it until taken; enter and leave on a falling edge
  task automatic send_word(sha1_pkg::word_t wd, logic [2:0] cnt, logic lst, logic fixed,
                           logic [159:0] known, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(14, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_msg_word   <= wd;
    in_byte_count <= cnt;
    in_last_word  <= lst;
    do @(posedge clk); while (in_stall);
    absorb_msg_word(wd, cnt, lst, fixed, known);
    words_in++;
    if (lst) begin
      messages++;
    end
    @(negedge clk);
  endtask

  // Sink: stall a random number of cycles before each digest word, with stall-free runs
  initial begin : digest_sink
    int  hold;
    bit  flowing;
    out_stall = 1'b1;
    flowing   = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(7, 0) == 0) begin
        flowing = !flowing;
      end
      hold = flowing ? 0 : $urandom_range(14, 0);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each taken digest word with the oldest expectation; watch for a hang
  always @(posedge clk) begin : digest_check
    digest_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $error("digest word %08h arrived with nothing expected", out_digest_word);
        fails++;
      end else begin
        exp_beat = digest_q.pop_front();
        if (out_digest_word !== exp_beat.word) begin
          $error("digest_word: expected %08h, actual %08h", exp_beat.word, out_digest_word);
          fails++;
        end
        if (out_digest_last !== exp_beat.last) begin
          $error("digest_last: expected %0b, actual %0b", exp_beat.last, out_digest_last);
          fails++;
        end
        digests_seen++;
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int  rand_words;
    int  len;
    bit  burst;
    fails         = 0;
    idle_cycles   = 0;
    words_in      = 0;
    messages      = 0;
    digests_seen  = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_msg_word   = '0;
    in_byte_count = '0;
    in_last_word  = 1'b0;
    start_message();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(DIR_TABLE[i].data, DIR_TABLE[i].count, DIR_TABLE[i].last,
                DIR_TABLE[i].fixed, DIR_TABLE[i].digest, 1'b0);
    end

    // Random messages, lengths biased towards the block and padding boundaries
    rand_words = 0;
    while (rand_words < RANDOM_WORDS) begin
      case ($urandom_range(9, 0))
        0:       len = 0;
        1, 2:    len = $urandom_range(16, 12);
        3:       len = $urandom_range(34, 27);
        4:       len = $urandom_range(64, 40);
        default: len = $urandom_range(11, 1);
      endcase
      // Trim the final message so the word total stays on target
      if (len > RANDOM_WORDS - rand_words - 1) begin
        len = RANDOM_WORDS - rand_words - 1;
      end
      burst = ($urandom_range(3, 0) == 0);
      for (int j = 0; j < len; j++) begin
        send_word($urandom, 3'($urandom_range(7, 0)), 1'b0, 1'b0, NO_DIGEST, burst);
      end
      send_word($urandom, 3'($urandom_range(7, 0)), 1'b1, 1'b0, NO_DIGEST, burst);
      rand_words += len + 1;
    end
    in_valid <= 1'b0;

    // Drain the outstanding digests, then watch for stray output
    while (digest_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d message words in %0d messages", words_in, messages);
    $display("%0d digest words compared, %0d mismatches", digests_seen, fails);
    if (fails == 0 && digest_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
